[rtl/lap_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lap_pkg
// Shared types and constants for the address lease pool.
// ---------------------------------------------------------------------------
package lap_pkg;

    localparam int POOL_DEPTH      = 1024;
    localparam int IDX_W           = $clog2(POOL_DEPTH);
    localparam int CNT_W           = IDX_W + 1;
    localparam int CLIENT_ID_WIDTH = 16;
    localparam int TIME_WIDTH      = 32;
    localparam int ADDR_W          = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int POOL_SIZE_W     = 11;

    typedef logic [TIME_WIDTH-1:0]      time_t;
    typedef logic [CLIENT_ID_WIDTH-1:0] client_t;
    typedef logic [IDX_W-1:0]           idx_t;
    typedef logic [CNT_W-1:0]           cnt_t;

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_PENDING  = 2'd1,
        ST_OCCUPIED = 2'd2,
        ST_EXPIRED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        DST_SELF      = 2'd0,
        DST_BROADCAST = 2'd1,
        DST_OTHER     = 2'd2,
        DST_OTHER_ALT = 2'd3
    } dest_t;

    localparam logic [1:0] OP_DISCOVER = 2'd0;
    localparam logic [1:0] OP_REQUEST  = 2'd1;

    localparam logic [1:0] RK_OFFER = 2'd0;
    localparam logic [1:0] RK_ACK   = 2'd1;
    localparam logic [1:0] RK_NAK   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LEASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEASE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEASE     = 2'd3;

    typedef struct packed {
        status_t status;
        client_t owner;
        time_t   expiry;
    } entry_t;

    // operands handed to the lease unit
    typedef struct packed {
        time_t now;
        time_t asked;
        time_t dflt;
        time_t lo;
        time_t hi;
    } lease_req_t;

endpackage

[rtl/lap_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lap_if
// Channel interfaces: message in, reply out, configuration write.
// ---------------------------------------------------------------------------
interface lap_msg_if;
    logic                               valid;
    logic                               ready;
    lap_pkg::time_t                     arrival_time;
    lap_pkg::client_t                   client_id;
    logic [1:0]                         destination;
    logic [1:0]                         operation;
    logic [lap_pkg::ADDR_W-1:0]         requested_address;
    lap_pkg::time_t                     requested_expiry;
    modport source (output valid, arrival_time, client_id, destination, operation,
                    requested_address, requested_expiry, input ready);
    modport sink   (input valid, arrival_time, client_id, destination, operation,
                    requested_address, requested_expiry, output ready);
endinterface

interface lap_reply_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         reply_kind;
    lap_pkg::client_t                   reply_client;
    logic [lap_pkg::ADDR_W-1:0]         reply_address;
    lap_pkg::time_t                     reply_expiry;
    modport source (output valid, reply_kind, reply_client, reply_address, reply_expiry,
                    input ready);
    modport sink   (input valid, reply_kind, reply_client, reply_address, reply_expiry,
                    output ready);
endinterface

interface lap_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [lap_pkg::CFG_IDX_W-1:0]      index;
    logic [lap_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/address_lease_pool.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// address_lease_pool
// Lease pool sequencer: ages and scans every entry of the active pool per message.
// ---------------------------------------------------------------------------
//  channel | dir | transfer carries
//  msg     | in  | arrival_time, client_id, destination, operation, address, expiry
//  reply   | out | reply_kind, reply_client, reply_address, reply_expiry
//  cfg     | in  | index, data (always ready)
//
//  The scan reads and writes back one entry per cycle over the active pool,
//  then the lease unit runs; a request to this server adds an ownership check.
//  After reset a clearing pass over all POOL_DEPTH (1024) entries zeroes the
//  store; msg is not ready meanwhile. A finished reply waits in an output
//  register while the next message is accepted; a stalled reply holds the
//  sequencer only when the next result is ready.
// ---------------------------------------------------------------------------
module address_lease_pool (
    input  logic clk,
    input  logic rst_n,
    lap_msg_if.sink     msg,
    lap_reply_if.source reply,
    lap_cfg_if.sink     cfg
);
    import lap_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SWEEP, S_DRAIN, S_LWAIT, S_RDK, S_KCHK, S_EMIT
    } state_t;

    state_t  state_reg;
    idx_t    idx_reg;
    cnt_t    n_reg;

    // configuration
    logic [POOL_SIZE_W-1:0] pool_size_reg;
    time_t   default_lease_reg;
    time_t   max_lease_reg;
    time_t   min_lease_reg;

    // latched message
    time_t            now_reg;
    client_t          client_reg;
    logic [1:0]       dest_reg;
    logic [1:0]       op_reg;
    logic [ADDR_W-1:0] addr_reg;
    time_t            asked_reg;

    // write-back stage of the scan
    logic    p_valid_reg;
    idx_t    p_idx_reg;

    // search results
    logic    own_found_reg;
    idx_t    own_idx_reg;
    logic    free_found_reg;
    idx_t    free_idx_reg;
    logic    exp_found_reg;
    idx_t    exp_idx_reg;

    // result staging and output register
    logic [1:0]        res_kind_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    time_t             res_expiry_reg;
    logic              out_valid_reg;
    logic [1:0]        out_kind_reg;
    client_t           out_client_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    time_t             out_expiry_reg;

    // memory ports
    logic    mem_we;
    idx_t    mem_waddr;
    entry_t  mem_wdata;
    idx_t    mem_raddr;
    entry_t  mem_rdata;

    // lease unit
    logic       lease_start;
    lease_req_t lease_req;
    logic       lease_done;
    time_t      lease_exp;

    entry_t  aged;
    entry_t  scanned;
    cnt_t    n_clamped;
    logic    is_discover;
    logic    is_release;
    logic    is_self_req;
    logic    addr_ok;
    logic    have_pick;
    idx_t    pick;
    idx_t    k_idx;
    logic    k_owned;
    logic    out_free;

    lap_entry_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lap_lease_unit u_lease (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lease_start),
        .req    (lease_req),
        .done   (lease_done),
        .expiry (lease_exp)
    );

    assign is_discover = (op_reg == OP_DISCOVER) && (dest_reg == DST_BROADCAST);
    assign is_release  = (op_reg == OP_REQUEST)
                         && ((dest_reg == DST_OTHER) || (dest_reg == DST_OTHER_ALT));
    assign is_self_req = (op_reg == OP_REQUEST) && (dest_reg == DST_SELF);
    assign addr_ok     = (addr_reg != '0) && (addr_reg <= ADDR_W'(n_reg));
    assign k_idx       = IDX_W'(addr_reg - 1'b1);
    assign k_owned     = (mem_rdata.status != ST_FREE) && (mem_rdata.owner == client_reg);
    assign out_free    = !out_valid_reg || reply.ready;

    // pool size 0 acts as 1, anything above the depth as the depth
    always_comb
    begin
        if (pool_size_reg == '0)
            n_clamped = cnt_t'(1);
        else if (CNT_W'(pool_size_reg) > cnt_t'(POOL_DEPTH))
            n_clamped = cnt_t'(POOL_DEPTH);
        else
            n_clamped = CNT_W'(pool_size_reg);
    end

    // aging of the entry read back, then release of pending entries
    always_comb
    begin
        aged = mem_rdata;
        if ((mem_rdata.expiry != '0) && (mem_rdata.expiry <= now_reg))
        begin
            if (mem_rdata.status == ST_PENDING)
            begin
                aged.status = ST_FREE;
                aged.owner  = '0;
            end
            else
            begin
                aged.status = ST_EXPIRED;
            end
            aged.expiry = '0;
        end
        scanned = aged;
        if (is_release && (aged.status == ST_PENDING) && (aged.owner == client_reg))
            scanned = '0;
    end

    always_comb
    begin
        have_pick = own_found_reg || free_found_reg || exp_found_reg;
        if (own_found_reg)
            pick = own_idx_reg;
        else if (free_found_reg)
            pick = free_idx_reg;
        else
            pick = exp_idx_reg;
    end

    always_comb
    begin
        lease_start     = (state_reg == S_DRAIN);
        lease_req.now   = now_reg;
        lease_req.asked = asked_reg;
        lease_req.dflt  = default_lease_reg;
        lease_req.lo    = min_lease_reg;
        lease_req.hi    = max_lease_reg;
    end

    // one write per cycle; the cases never overlap
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = p_idx_reg;
        mem_wdata = scanned;
        mem_raddr = idx_reg;
        if (state_reg == S_CLR)
        begin
            mem_we    = 1'b1;
            mem_waddr = idx_reg;
            mem_wdata = '0;
        end
        else if (p_valid_reg)
        begin
            mem_we = 1'b1;
        end
        else if ((state_reg == S_LWAIT) && lease_done && is_discover && have_pick)
        begin
            mem_we           = 1'b1;
            mem_waddr        = pick;
            mem_wdata.status = ST_PENDING;
            mem_wdata.owner  = client_reg;
            mem_wdata.expiry = lease_exp;
        end
        else if ((state_reg == S_KCHK) && k_owned)
        begin
            mem_we           = 1'b1;
            mem_waddr        = k_idx;
            mem_wdata.status = ST_OCCUPIED;
            mem_wdata.owner  = mem_rdata.owner;
            mem_wdata.expiry = lease_exp;
        end
        // hold the named entry on the read port until the ownership check
        if ((state_reg == S_LWAIT) || (state_reg == S_RDK))
            mem_raddr = k_idx;
    end

    // configuration port
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg     <= POOL_SIZE_W'(POOL_DEPTH);
            default_lease_reg <= '0;
            max_lease_reg     <= '0;
            min_lease_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_POOL_SIZE:     pool_size_reg     <= cfg.data[POOL_SIZE_W-1:0];
                CFG_DEFAULT_LEASE: default_lease_reg <= cfg.data;
                CFG_MAX_LEASE:     max_lease_reg     <= cfg.data;
                CFG_MIN_LEASE:     min_lease_reg     <= cfg.data;
                default:           ;
            endcase
        end
    end

    assign msg.ready = (state_reg == S_IDLE);

    // message latch
    always_ff @(posedge clk)
    begin
        if (msg.valid && msg.ready)
        begin
            now_reg    <= msg.arrival_time;
            client_reg <= msg.client_id;
            dest_reg   <= msg.destination;
            op_reg     <= msg.operation;
            addr_reg   <= msg.requested_address;
            asked_reg  <= msg.requested_expiry;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            idx_reg        <= '0;
            n_reg          <= '0;
            p_valid_reg    <= 1'b0;
            p_idx_reg      <= '0;
            own_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            exp_found_reg  <= 1'b0;
            own_idx_reg    <= '0;
            free_idx_reg   <= '0;
            exp_idx_reg    <= '0;
            res_kind_reg   <= RK_OFFER;
            res_addr_reg   <= '0;
            res_expiry_reg <= '0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= RK_OFFER;
            out_client_reg <= '0;
            out_addr_reg   <= '0;
            out_expiry_reg <= '0;
        end
        else
        begin
            // in S_EMIT the output register is reloaded below instead
            if (reply.valid && reply.ready && (state_reg != S_EMIT))
                out_valid_reg <= 1'b0;

            p_valid_reg <= (state_reg == S_SWEEP);
            p_idx_reg   <= idx_reg;

            // track first owned, first free and first expired entry
            if (p_valid_reg)
            begin
                if (!own_found_reg && (aged.status != ST_FREE) && (aged.owner == client_reg))
                begin
                    own_found_reg <= 1'b1;
                    own_idx_reg   <= p_idx_reg;
                end
                if (!free_found_reg && (aged.status == ST_FREE))
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= p_idx_reg;
                end
                if (!exp_found_reg && (aged.status == ST_EXPIRED))
                begin
                    exp_found_reg <= 1'b1;
                    exp_idx_reg   <= p_idx_reg;
                end
            end

            unique case (state_reg)
                S_CLR:
                begin
                    if (idx_reg == idx_t'(POOL_DEPTH - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (msg.valid)
                    begin
                        n_reg          <= n_clamped;
                        idx_reg        <= '0;
                        own_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        exp_found_reg  <= 1'b0;
                        state_reg      <= S_SWEEP;
                    end
                end
                S_SWEEP:
                begin
                    if (CNT_W'(idx_reg) == n_reg - 1'b1)
                        state_reg <= S_DRAIN;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_DRAIN:
                begin
                    state_reg <= S_LWAIT;
                end
                S_LWAIT:
                begin
                    if (lease_done)
                    begin
                        res_addr_reg <= addr_reg;
                        if (is_discover)
                        begin
                            res_kind_reg   <= RK_OFFER;
                            res_addr_reg   <= ADDR_W'(pick) + 1'b1;
                            res_expiry_reg <= lease_exp;
                            state_reg      <= have_pick ? S_EMIT : S_IDLE;
                        end
                        else if (is_self_req && addr_ok)
                        begin
                            state_reg <= S_RDK;
                        end
                        else if (is_self_req)
                        begin
                            res_kind_reg   <= RK_NAK;
                            res_expiry_reg <= '0;
                            state_reg      <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_RDK:
                begin
                    state_reg <= S_KCHK;
                end
                S_KCHK:
                begin
                    res_kind_reg   <= k_owned ? RK_ACK : RK_NAK;
                    res_expiry_reg <= k_owned ? lease_exp : '0;
                    state_reg      <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_kind_reg   <= res_kind_reg;
                        out_client_reg <= client_reg;
                        out_addr_reg   <= res_addr_reg;
                        out_expiry_reg <= res_expiry_reg;
                        state_reg      <= S_IDLE;
                    end
                    else if (reply.valid && reply.ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign reply.valid         = out_valid_reg;
    assign reply.reply_kind    = out_kind_reg;
    assign reply.reply_client  = out_client_reg;
    assign reply.reply_address = out_addr_reg;
    assign reply.reply_expiry  = out_expiry_reg;

    // a message is only taken between scans, never during the clearing pass
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (msg.valid && msg.ready) |-> (state_reg == S_IDLE))
        else $error("message accepted while busy");

    // the scan never runs past the active pool size
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (CNT_W'(idx_reg) < n_reg))
        else $error("scan index beyond pool size");

    // a refusal always carries zero expiry
    a_nak_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (reply.valid && (reply.reply_kind == RK_NAK)) |-> (reply.reply_expiry == '0))
        else $error("nak with nonzero expiry");

    // the lease unit answers through its v1 and done registers after the scan drains
    a_lease_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> ##2 lease_done)
        else $error("lease unit latency broken");
endmodule

[rtl/lap_entry_mem.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lap_entry_mem
// Lease entry store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module lap_entry_mem (
    input  logic            clk,
    input  logic            we,
    input  lap_pkg::idx_t   waddr,
    input  lap_pkg::entry_t wdata,
    input  lap_pkg::idx_t   raddr,
    output lap_pkg::entry_t rdata
);
    import lap_pkg::*;

    entry_t mem [POOL_DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[rtl/lap_lease_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lap_lease_unit
// Two-stage lease end calculation: clamp select, then saturating add.
// ---------------------------------------------------------------------------
module lap_lease_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  lap_pkg::lease_req_t req,
    output logic                done,
    output lap_pkg::time_t      expiry
);
    import lap_pkg::*;

    logic  v1_reg;
    logic  use_asked_reg;
    time_t addend_reg;
    time_t now_reg;
    time_t asked_reg;
    logic  done_reg;
    time_t expiry_reg;

    time_t                addend_next;
    logic                 use_asked_next;
    time_t                span;
    logic [TIME_WIDTH:0]  sum;

    always_comb
    begin
        span           = req.asked - req.now;
        use_asked_next = 1'b0;
        addend_next    = req.lo;
        if (req.asked == '0)
            addend_next = req.dflt;
        else if (req.asked < req.now)
            addend_next = req.lo;
        else if (span > req.hi)
            addend_next = req.hi;
        else if (span < req.lo)
            addend_next = req.lo;
        else
            use_asked_next = 1'b1;
    end

    assign sum = {1'b0, now_reg} + {1'b0, addend_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            addend_reg    <= addend_next;
            use_asked_reg <= use_asked_next;
            now_reg       <= req.now;
            asked_reg     <= req.asked;
        end
        if (v1_reg)
        begin
            if (use_asked_reg)
                expiry_reg <= asked_reg;
            else if (sum[TIME_WIDTH])
                expiry_reg <= '1;
            else
                expiry_reg <= sum[TIME_WIDTH-1:0];
        end
    end

    assign done   = done_reg;
    assign expiry = expiry_reg;
endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking regression for address_lease_pool. A lease-pool predictor
// tracks every entry and the limit registers. Each accepted message is fed to
// it, and every reply transfer is compared against the oldest expected reply.
// A directed table runs first. Then come random discover/request sequences
// under several register settings, with random idling on both channels.
// ---------------------------------------------------------------------------
module testbench;
    import lap_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int DRAIN_CYCLES = POOL_DEPTH + 80;   // longest message plus slack
    localparam int HOLD_CYCLES  = 3000;

    // how a table row is checked
    localparam int EXP_PREDICT = 0;
    localparam int EXP_REPLY   = 1;
    localparam int EXP_NONE    = 2;

    typedef struct {
        time_t       at;
        client_t     cid;
        logic [1:0]  dst;
        logic [1:0]  op;
        logic [15:0] addr;
        time_t       ask;
    } msg_t;

    typedef struct {
        logic [1:0]  kind;
        client_t     cl;
        logic [15:0] addr;
        time_t       exp;
    } reply_t;

    typedef struct {
        msg_t   m;
        int     chk;
        reply_t r;
    } row_t;

    logic clk;
    logic rst_n;

    lap_msg_if   msg_ch ();
    lap_reply_if reply_ch ();
    lap_cfg_if   cfg_ch ();

    address_lease_pool uut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_ch),
        .reply (reply_ch),
        .cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Predictor state: full pool plus the limit registers.
    // ------------------------------------------------------------------
    status_t                lp_status [POOL_DEPTH];
    client_t                lp_owner  [POOL_DEPTH];
    time_t                  lp_expiry [POOL_DEPTH];
    logic [POOL_SIZE_W-1:0] lp_pool_size;
    time_t                  lp_dflt;
    time_t                  lp_hi;
    time_t                  lp_lo;

    reply_t replies_due [$];
    int     errors = 0;
    int     tx_idle;
    int     rx_idle;
    bit     hold_go;
    bit     hold_done = 1'b0;
    int     hold_cnt = 0;
    int     cycles = 0;
    reply_t last_reply;
    bit     last_got;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic time_t sat_sum(time_t a, time_t b);
        logic [TIME_WIDTH:0] s;
        s = a + b;
        return s[TIME_WIDTH] ? '1 : s[TIME_WIDTH-1:0];
    endfunction

    // Granted expiry: default lease for a zero ask, else span clamped to [min_lease, max_lease].
    function automatic time_t grant_expiry(time_t now, time_t asked);
        time_t span;
        if (asked == 0)
            return sat_sum(now, lp_dflt);
        if (asked < now)
            return sat_sum(now, lp_lo);
        span = asked - now;
        if (span > lp_hi)
            return sat_sum(now, lp_hi);
        if (span < lp_lo)
            return sat_sum(now, lp_lo);
        return asked;
    endfunction

    // One message through the pool: aging, then the action. Returns 1 when
    // the message produces a reply.
    function automatic bit lease_pool_step(input msg_t m, output reply_t r);
        int  n;
        int  pick;
        int  k;
        bit  owned;
        n = (lp_pool_size == 0) ? 1 : (lp_pool_size > POOL_DEPTH ? POOL_DEPTH : lp_pool_size);
        r = '{kind: RK_OFFER, cl: m.cid, addr: '0, exp: '0};
        for (int i = 0; i < n; i++)
        begin
            if (lp_expiry[i] != 0 && lp_expiry[i] <= m.at)
            begin
                if (lp_status[i] == ST_PENDING)
                begin
                    lp_status[i] = ST_FREE;
                    lp_owner[i]  = '0;
                end
                else
                    lp_status[i] = ST_EXPIRED;
                lp_expiry[i] = '0;
            end
        end
        if (m.op == OP_DISCOVER && m.dst == DST_BROADCAST)
        begin
            pick = -1;
            for (int i = 0; i < n && pick < 0; i++)
                if (lp_status[i] != ST_FREE && lp_owner[i] == m.cid)
                    pick = i;
            for (int i = 0; i < n && pick < 0; i++)
                if (lp_status[i] == ST_FREE)
                    pick = i;
            for (int i = 0; i < n && pick < 0; i++)
                if (lp_status[i] == ST_EXPIRED)
                    pick = i;
            if (pick < 0)
                return 1'b0;
            lp_status[pick] = ST_PENDING;
            lp_owner[pick]  = m.cid;
            lp_expiry[pick] = grant_expiry(m.at, m.ask);
            r.addr = 16'(pick + 1);
            r.exp  = lp_expiry[pick];
            return 1'b1;
        end
        if (m.op == OP_REQUEST && (m.dst == DST_OTHER || m.dst == DST_OTHER_ALT))
        begin
            // request to another server drops this client's pending offers
            for (int i = 0; i < n; i++)
                if (lp_status[i] == ST_PENDING && lp_owner[i] == m.cid)
                begin
                    lp_status[i] = ST_FREE;
                    lp_owner[i]  = '0;
                    lp_expiry[i] = '0;
                end
            return 1'b0;
        end
        if (m.op == OP_REQUEST && m.dst == DST_SELF)
        begin
            owned = 1'b0;
            k = 0;
            if (m.addr >= 1 && m.addr <= n)
            begin
                k = m.addr - 1;
                owned = lp_status[k] != ST_FREE && lp_owner[k] == m.cid;
            end
            r.addr = m.addr;
            if (!owned)
            begin
                r.kind = RK_NAK;
                return 1'b1;
            end
            lp_status[k] = ST_OCCUPIED;
            lp_expiry[k] = grant_expiry(m.at, m.ask);
            r.kind = RK_ACK;
            r.exp  = lp_expiry[k];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic msg_t mk_msg(time_t at, client_t c, logic [1:0] d, logic [1:0] o,
                                    logic [15:0] a, time_t e);
        msg_t m;
        m = '{at: at, cid: c, dst: d, op: o, addr: a, ask: e};
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Message sender. A gap, if any, starts in the step of the previous
    // transfer, so valid never gets two updates in one step.
    // ------------------------------------------------------------------
    task automatic send_msg(input msg_t m, input int chk, input reply_t typed);
        reply_t pr;
        while ($urandom_range(99) < tx_idle)
        begin
            msg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        msg_ch.valid             <= 1'b1;
        msg_ch.arrival_time      <= m.at;
        msg_ch.client_id         <= m.cid;
        msg_ch.destination       <= m.dst;
        msg_ch.operation         <= m.op;
        msg_ch.requested_address <= m.addr;
        msg_ch.requested_expiry  <= m.ask;
        @(posedge clk);
        while (!msg_ch.ready)
            @(posedge clk);
        last_got   = lease_pool_step(m, pr);
        last_reply = pr;
        if (chk == EXP_REPLY)
            replies_due.push_back(typed);
        else if (chk == EXP_PREDICT && last_got)
            replies_due.push_back(pr);
    endtask

    task automatic send_pred(input msg_t m);
        reply_t none;
        none = '{kind: '0, cl: '0, addr: '0, exp: '0};
        send_msg(m, EXP_PREDICT, none);
    endtask

    // Block is idle once every reply is in and the last scan has had time to end.
    task automatic wait_idle();
        msg_ch.valid <= 1'b0;
        wait (replies_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_POOL_SIZE:     lp_pool_size = val[POOL_SIZE_W-1:0];
            CFG_DEFAULT_LEASE: lp_dflt = val;
            CFG_MAX_LEASE:     lp_hi = val;
            default:           lp_lo = val;
        endcase
    endtask

    task automatic set_limits(input logic [31:0] ps, input logic [31:0] dl,
                              input logic [31:0] hi, input logic [31:0] lo);
        cfg_write(CFG_POOL_SIZE, ps);
        cfg_write(CFG_DEFAULT_LEASE, dl);
        cfg_write(CFG_MAX_LEASE, hi);
        cfg_write(CFG_MIN_LEASE, lo);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                tx_idle = 35;
                rx_idle = 84;
            end
            1:
            begin
                tx_idle = 84;
                rx_idle = 35;
            end
            default:
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
        endcase
    endtask

    function automatic time_t rand_ask(time_t now);
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return '0;
        if (r < 8)
            return (now > 32'hFFFF_FF00) ? time_t'('1) : now + $urandom_range(60);
        if (r == 8)
            return $urandom;
        return (now > 5) ? now - $urandom_range(1, 5) : '0;
    endfunction

    // Random traffic: mostly discover/request handshakes from a few clients,
    // some releases, stray requests and noise that the pool ignores.
    task automatic run_random(input int n_items, input time_t base, input bit squeeze);
        time_t   now;
        client_t c;
        int      done;
        int      r;
        logic [15:0] a;
        now  = base;
        done = 0;
        while (done < n_items)
        begin
            if (squeeze && done >= 20)
                hold_go = 1'b1;
            if (now < 32'hFFFF_FFF0)
                now = now + $urandom_range(12);
            c = ($urandom_range(9) == 0) ? client_t'($urandom_range(1, 65535))
                                         : client_t'($urandom_range(1, 6));
            r = $urandom_range(99);
            if (r < 70)
            begin
                send_pred(mk_msg(now, c, DST_BROADCAST, OP_DISCOVER,
                                 16'($urandom_range(65535)), rand_ask(now)));
                done++;
                if (last_got && $urandom_range(9) < 8)
                begin
                    a = ($urandom_range(9) == 0) ? 16'($urandom_range(65535)) : last_reply.addr;
                    if (now < 32'hFFFF_FFF0)
                        now = now + $urandom_range(4);
                    send_pred(mk_msg(now, c, DST_SELF, OP_REQUEST, a, rand_ask(now)));
                    done++;
                end
                if ($urandom_range(4) == 0)
                begin
                    send_pred(mk_msg(now, c, $urandom_range(1) ? DST_OTHER : DST_OTHER_ALT,
                                     OP_REQUEST, 16'($urandom_range(65535)), rand_ask(now)));
                    done++;
                end
            end
            else if (r < 85)
            begin
                a = $urandom_range(1) ? 16'($urandom_range(65535)) : 16'($urandom_range(20));
                send_pred(mk_msg(now, c, DST_SELF, OP_REQUEST, a, rand_ask(now)));
                done++;
            end
            else
            begin
                // ignored: other types, discover not broadcast, broadcast request
                case ($urandom_range(2))
                    0: send_pred(mk_msg(now, c, 2'($urandom_range(3)), 2'($urandom_range(2, 3)),
                                        16'($urandom_range(65535)), $urandom));
                    1: send_pred(mk_msg(now, c, $urandom_range(1) ? DST_SELF : DST_OTHER_ALT,
                                        OP_DISCOVER, 16'($urandom_range(65535)), $urandom));
                    default: send_pred(mk_msg(now, c, DST_BROADCAST, OP_REQUEST,
                                              16'($urandom_range(65535)), $urandom));
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Reply receiver: random ready, plus one long hold-off on request.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
            reply_ch.ready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            reply_ch.ready <= 1'b0;
        end
        else
            reply_ch.ready <= ($urandom_range(99) >= rx_idle);
    end

    // Reply checker: each transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && reply_ch.valid && reply_ch.ready)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: unexpected reply kind=%0d client=%0h addr=%0d expiry=%0h",
                         $time, reply_ch.reply_kind, reply_ch.reply_client,
                         reply_ch.reply_address, reply_ch.reply_expiry);
                errors++;
            end
            else
            begin
                reply_t e;
                e = replies_due.pop_front();
                if (reply_ch.reply_kind !== e.kind)
                begin
                    $display("%0t: reply_kind expected %0d got %0d",
                             $time, e.kind, reply_ch.reply_kind);
                    errors++;
                end
                if (reply_ch.reply_client !== e.cl)
                begin
                    $display("%0t: reply_client expected %0h got %0h",
                             $time, e.cl, reply_ch.reply_client);
                    errors++;
                end
                if (reply_ch.reply_address !== e.addr)
                begin
                    $display("%0t: reply_address expected %0d got %0d",
                             $time, e.addr, reply_ch.reply_address);
                    errors++;
                end
                if (reply_ch.reply_expiry !== e.exp)
                begin
                    $display("%0t: reply_expiry expected %0h got %0h",
                             $time, e.exp, reply_ch.reply_expiry);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("address_lease_pool regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table. Typed rows hold the obvious answers at reset limits
    // (all leases zero, so expiry equals arrival time); the rest go to the
    // predictor.
    // ------------------------------------------------------------------
    localparam time_t TMAX = '1;
    row_t dir_rows [] = '{
        // first discover takes address 1, zero lease at time 0 never times out
        '{'{0, 1, DST_BROADCAST, OP_DISCOVER, 0, 0}, EXP_REPLY, '{RK_OFFER, 1, 1, 0}},
        '{'{0, 1, DST_SELF, OP_REQUEST, 1, 0}, EXP_REPLY, '{RK_ACK, 1, 1, 0}},
        // client's own entry is offered again
        '{'{0, 1, DST_BROADCAST, OP_DISCOVER, 0, 0}, EXP_REPLY, '{RK_OFFER, 1, 1, 0}},
        // not the owner, address zero, far out of range, just past the pool
        '{'{0, 2, DST_SELF, OP_REQUEST, 1, 0}, EXP_REPLY, '{RK_NAK, 2, 1, 0}},
        '{'{0, 1, DST_SELF, OP_REQUEST, 0, 0}, EXP_REPLY, '{RK_NAK, 1, 0, 0}},
        '{'{0, 1, DST_SELF, OP_REQUEST, 16'hFFFF, 0}, EXP_REPLY, '{RK_NAK, 1, 16'hFFFF, 0}},
        '{'{0, 1, DST_SELF, OP_REQUEST, 1025, 0}, EXP_REPLY, '{RK_NAK, 1, 1025, 0}},
        // ignored messages
        '{'{0, 1, DST_SELF, OP_DISCOVER, 0, 0}, EXP_NONE, '{0, 0, 0, 0}},
        '{'{0, 1, DST_BROADCAST, 2'd2, 0, 0}, EXP_NONE, '{0, 0, 0, 0}},
        '{'{0, 1, DST_OTHER_ALT, 2'd3, 16'hFFFF, TMAX}, EXP_NONE, '{0, 0, 0, 0}},
        '{'{0, 1, DST_BROADCAST, OP_REQUEST, 1, 0}, EXP_NONE, '{0, 0, 0, 0}},
        // request elsewhere frees the pending entry, which is then reused
        '{'{0, 1, DST_OTHER, OP_REQUEST, 1, 0}, EXP_NONE, '{0, 0, 0, 0}},
        '{'{0, 16'hFFFF, DST_BROADCAST, OP_DISCOVER, 0, 0}, EXP_REPLY,
          '{RK_OFFER, 16'hFFFF, 1, 0}},
        '{'{5, 3, DST_BROADCAST, OP_DISCOVER, 0, 100}, EXP_PREDICT, '{0, 0, 0, 0}},
        '{'{5, 3, DST_OTHER_ALT, OP_REQUEST, 0, 0}, EXP_PREDICT, '{0, 0, 0, 0}},
        '{'{10, 4, DST_BROADCAST, OP_DISCOVER, 0, TMAX}, EXP_PREDICT, '{0, 0, 0, 0}},
        // latest time: pending offer lapses, request gets a nak
        '{'{TMAX, 4, DST_SELF, OP_REQUEST, 2, 0}, EXP_PREDICT, '{0, 0, 0, 0}},
        '{'{TMAX, 16'hFFFF, DST_SELF, OP_REQUEST, 1, TMAX}, EXP_PREDICT, '{0, 0, 0, 0}},
        '{'{TMAX, 16'hAAAA, DST_BROADCAST, OP_DISCOVER, 16'h5555, 32'h5555AAAA},
          EXP_PREDICT, '{0, 0, 0, 0}}
    };

    initial
    begin
        hold_go   = 1'b0;
        rst_n     = 1'b0;
        msg_ch.valid             = 1'b0;
        msg_ch.arrival_time      = '0;
        msg_ch.client_id         = '0;
        msg_ch.destination       = '0;
        msg_ch.operation         = '0;
        msg_ch.requested_address = '0;
        msg_ch.requested_expiry  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            lp_status[i] = ST_FREE;
            lp_owner[i]  = '0;
            lp_expiry[i] = '0;
        end
        lp_pool_size = POOL_SIZE_W'(POOL_DEPTH);
        lp_dflt = '0;
        lp_hi   = '0;
        lp_lo   = '0;
        set_idling(0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_msg(dir_rows[i].m, dir_rows[i].chk, dir_rows[i].r);
        wait_idle();

        // random phases: pool size extremes and lease limits that saturate
        set_limits(0, 7, 30, 3);
        run_random(40, 0, 1'b0);
        wait_idle();
        set_limits(4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        run_random(80, 100, 1'b0);
        wait_idle();
        set_idling(1);
        set_limits(8, 20, 40, 5);
        run_random(100, 1000, 1'b1);     // long reply hold-off here
        wait_idle();
        set_limits(2047, 10, 50, 2);
        run_random(12, 5000, 1'b0);
        wait_idle();
        set_idling(2);
        set_limits(16, 0, 0, 0);
        run_random(100, 9000, 1'b0);
        wait_idle();
        set_limits(3, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(80, 32'hFFFF_FE00, 1'b0);
        wait_idle();
        set_idling(0);
        set_limits(1, 5, 10, 20);        // min above max
        run_random(60, 200, 1'b0);
        wait_idle();
        set_idling(1);
        set_limits(12, 25, 60, 8);
        run_random(100, 30000, 1'b0);
        wait_idle();

        if (errors == 0 && replies_due.size() == 0)
            $display("address_lease_pool regression: pass");
        else
            $display("address_lease_pool regression: fail");
        $finish;
    end

endmodule

[address_lease_pool.f]
rtl/lap_pkg.sv
rtl/lap_if.sv
rtl/lap_entry_mem.sv
rtl/lap_lease_unit.sv
rtl/address_lease_pool.sv
tb/sv/testbench.sv
